// ----- sv/lobm_pkg.sv -----
package lobm_pkg;

    typedef enum logic [2:0] {
        ST_TRADE   = 3'd0,
        ST_RESTED  = 3'd1,
        ST_DONE    = 3'd2,
        ST_DROPPED = 3'd3,
        ST_CANCEL  = 3'd4,
        ST_NOTFND  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_RDWAIT,
        S_TRADE,
        S_FINISH,
        S_OUT
    } fsm_t;

    localparam logic CMD_NEW    = 1'b0;
    localparam logic CMD_CANCEL = 1'b1;

endpackage

// ----- sv/lobm_ram.sv -----
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/lobm_scan.sv -----
// scan compare unit: one slot per cycle while step is high, keeps best crossing candidate or id match
module lobm_scan import lobm_pkg::*; #(
    parameter int AW         = 5,
    parameter int PRICE_BITS = 20,
    parameter int ID_BITS    = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  step,
    input  logic                  cancel,
    input  logic                  buy,
    input  logic [PRICE_BITS-1:0] limit,
    input  logic [ID_BITS-1:0]    ident,
    input  logic [31:0]           counter,
    input  logic                  s_valid,
    input  logic                  s_side,
    input  logic [PRICE_BITS-1:0] s_price,
    input  logic [ID_BITS-1:0]    s_ident,
    input  logic [31:0]           s_arrival,
    output logic                  found,
    output logic [AW-1:0]         best_idx
);

    logic                  found_reg;
    logic [AW-1:0]         idx_reg;
    logic [AW-1:0]         cur_reg;
    logic [PRICE_BITS-1:0] bprice_reg;
    logic [31:0]           bage_reg;
    logic [31:0]           age;
    logic                  cand;
    logic                  better;

    assign age = counter - s_arrival;

    always_comb
    begin
        if (cancel)
        begin
            cand   = s_valid && (s_ident == ident) && !found_reg;
            better = cand;
        end
        else
        begin
            cand = s_valid && (s_side != buy) &&
                   (buy ? (s_price <= limit) : (s_price >= limit));
            if (!found_reg)
                better = cand;
            else if (s_price != bprice_reg)
                better = cand && (buy ? (s_price < bprice_reg) : (s_price > bprice_reg));
            else
                better = cand && (age > bage_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            cur_reg   <= '0;
        end
        else if (start)
        begin
            found_reg <= 1'b0;
            cur_reg   <= '0;
        end
        else if (step)
        begin
            cur_reg <= cur_reg + AW'(1);
            if (better)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && better)
        begin
            idx_reg    <= cur_reg;
            bprice_reg <= s_price;
            bage_reg   <= age;
        end
    end

    assign found    = found_reg;
    assign best_idx = idx_reg;

endmodule

// ----- sv/limit_order_book_matcher_core.sv -----
// Single-symbol limit order book, price-time priority, SLOTS resting orders.
// Commands are taken one at a time; s_tready is low while one is worked on.
// Every fill costs one scan over all SLOTS slots through the shared compare unit
// followed by the decide, read-wait, trade and output states; a new order ends
// with one more scan, then decide, finish and output, and a cancel is one scan,
// decide and output. Each result word waits in the output register
// until m_tready; tlast marks the status word that ends a command.
module limit_order_book_matcher_core import lobm_pkg::*; #(
    parameter int SLOTS      = 32,
    parameter int PRICE_BITS = 20,
    parameter int QTY_BITS   = 24,
    parameter int ID_BITS    = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // order_id, is_buy, limit_price, order_qty, zero fill
    input  logic [((1+ID_BITS+PRICE_BITS+QTY_BITS+7)/8)*8-1:0] s_tdata,
    // cmd
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // maker_id, taker_id, fill_price, fill_qty, zero fill
    output logic [((2*ID_BITS+PRICE_BITS+QTY_BITS+7)/8)*8-1:0] m_tdata,
    // status
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    localparam int AW = $clog2(SLOTS);
    localparam int OW = ((2*ID_BITS+PRICE_BITS+QTY_BITS+7)/8)*8;
    localparam int SW = PRICE_BITS + ID_BITS + 32;

    fsm_t state_reg, state_next;
    logic [SLOTS-1:0]      valid_reg;
    logic [SLOTS-1:0]      side_reg;
    logic                  cmd_reg;
    logic                  buy_reg;
    logic [ID_BITS-1:0]    id_reg;
    logic [PRICE_BITS-1:0] limit_reg;
    logic [QTY_BITS-1:0]   qty_reg;
    logic [31:0]           counter_reg;
    logic [AW-1:0]         cnt_reg;
    logic                  out_valid_reg;
    logic                  out_last_reg;
    logic [OW-1:0]         out_data_reg;
    status_t               out_status_reg;

    logic                  scan_start, scan_step, found;
    logic [AW-1:0]         best_idx;
    logic [AW-1:0]         raddr;
    logic [SW-1:0]         st_rdata, st_wdata;
    logic [QTY_BITS-1:0]   q_rdata, q_wdata;
    logic                  st_we, q_we;
    logic [AW-1:0]         waddr;
    logic [QTY_BITS-1:0]   traded;
    logic [AW-1:0]         free_idx;
    logic                  free_found;
    logic [PRICE_BITS-1:0] r_price;
    logic [ID_BITS-1:0]    r_ident;
    logic [31:0]           r_arrival;
    logic                  scan_cur_valid;

    assign {r_arrival, r_ident, r_price} = st_rdata;

    lobm_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_static (
        .clk(clk), .we(st_we), .waddr(waddr), .wdata(st_wdata),
        .raddr(raddr), .rdata(st_rdata)
    );

    lobm_ram #(.WIDTH(QTY_BITS), .DEPTH(SLOTS)) u_qty (
        .clk(clk), .we(q_we), .waddr(waddr), .wdata(q_wdata),
        .raddr(raddr), .rdata(q_rdata)
    );

    // scan index is the ram read address of the previous cycle, registered in lag_reg
    logic [AW-1:0] lag_reg;
    always_ff @(posedge clk)
    begin
        lag_reg <= raddr;
    end
    assign scan_cur_valid = valid_reg[lag_reg];

    lobm_scan #(.AW(AW), .PRICE_BITS(PRICE_BITS), .ID_BITS(ID_BITS)) u_scan (
        .clk(clk), .rst_n(rst_n), .start(scan_start), .step(scan_step),
        .cancel(cmd_reg == CMD_CANCEL), .buy(buy_reg), .limit(limit_reg), .ident(id_reg),
        .counter(counter_reg), .s_valid(scan_cur_valid), .s_side(side_reg[lag_reg]),
        .s_price(r_price), .s_ident(r_ident), .s_arrival(r_arrival),
        .found(found), .best_idx(best_idx)
    );

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    assign traded = (qty_reg < q_rdata) ? qty_reg : q_rdata;

    function automatic logic [OW-1:0] pack(input logic [ID_BITS-1:0] mk,
                                           input logic [ID_BITS-1:0] tk,
                                           input logic [PRICE_BITS-1:0] pr,
                                           input logic [QTY_BITS-1:0] q);
        pack = OW'({q, pr, tk, mk});
    endfunction

    logic                  load_out;
    logic [OW-1:0]         out_next;
    status_t               status_next;
    logic                  last_next;

    always_comb
    begin
        state_next  = state_reg;
        scan_start  = 1'b0;
        scan_step   = 1'b0;
        raddr       = cnt_reg;
        st_we       = 1'b0;
        q_we        = 1'b0;
        waddr       = best_idx;
        st_wdata    = {counter_reg, id_reg, limit_reg};
        q_wdata     = q_rdata - traded;
        load_out    = 1'b0;
        out_next    = '0;
        status_next = ST_TRADE;
        last_next   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    scan_start = 1'b1;
                    raddr      = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                scan_step = 1'b1;
                raddr     = (cnt_reg == AW'(SLOTS - 1)) ? '0 : cnt_reg + AW'(1);
                if (cnt_reg == AW'(SLOTS - 1))
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                raddr = best_idx;
                if (cmd_reg == CMD_CANCEL)
                begin
                    load_out   = 1'b1;
                    last_next  = 1'b1;
                    out_next   = pack('0, id_reg, '0, '0);
                    if (found)
                        status_next = ST_CANCEL;
                    else
                        status_next = ST_NOTFND;
                    state_next = S_OUT;
                end
                else if (found && qty_reg != '0)
                    state_next = S_RDWAIT;
                else
                    state_next = S_FINISH;
            end
            S_RDWAIT:
            begin
                raddr      = best_idx;
                state_next = S_TRADE;
            end
            S_TRADE:
            begin
                raddr       = best_idx;
                q_we        = 1'b1;
                load_out    = 1'b1;
                out_next    = pack(r_ident, id_reg, r_price, traded);
                status_next = ST_TRADE;
                state_next  = S_OUT;
            end
            S_FINISH:
            begin
                load_out  = 1'b1;
                last_next = 1'b1;
                if (qty_reg == '0)
                begin
                    out_next    = pack('0, id_reg, '0, '0);
                    status_next = ST_DONE;
                end
                else if (free_found)
                begin
                    out_next    = pack('0, id_reg, limit_reg, qty_reg);
                    status_next = ST_RESTED;
                    st_we       = 1'b1;
                    q_we        = 1'b1;
                    waddr       = free_idx;
                    q_wdata     = qty_reg;
                end
                else
                begin
                    out_next    = pack('0, id_reg, limit_reg, qty_reg);
                    status_next = ST_DROPPED;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    if (out_last_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        scan_start = 1'b1;
                        raddr      = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            counter_reg   <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (scan_start)
                cnt_reg <= '0;
            else if (scan_step)
                cnt_reg <= cnt_reg + AW'(1);
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= last_next;
            end
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_DECIDE && cmd_reg == CMD_CANCEL && found)
                valid_reg[best_idx] <= 1'b0;
            if (state_reg == S_TRADE && traded == q_rdata)
                valid_reg[best_idx] <= 1'b0;
            if (state_reg == S_FINISH && qty_reg != '0 && free_found)
            begin
                valid_reg[free_idx] <= 1'b1;
                counter_reg         <= counter_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
        begin
            cmd_reg   <= s_tuser;
            id_reg    <= s_tdata[0 +: ID_BITS];
            buy_reg   <= s_tdata[ID_BITS];
            limit_reg <= s_tdata[ID_BITS + 1 +: PRICE_BITS];
            qty_reg   <= s_tdata[ID_BITS + 1 + PRICE_BITS +: QTY_BITS];
        end
        else if (state_reg == S_TRADE)
            qty_reg <= qty_reg - traded;
        if (state_reg == S_FINISH && qty_reg != '0 && free_found)
            side_reg[free_idx] <= buy_reg;
        if (load_out)
        begin
            out_data_reg   <= out_next;
            out_status_reg <= status_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- sv/lobm_checker.sv -----
module lobm_checker (
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic m_tlast
);

    // no new command while a result word is pending
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input ready while output pending");

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tlast))
        else $error("output dropped under stall");

    // command taken leaves the block busy
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready after accept");

endmodule

bind limit_order_book_matcher_core lobm_checker u_lobm_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast)
);
